@@ rtl/pcf_pkg.sv @@
`timescale 1ns / 1ps
package pcf_pkg;

  // chain geometry: the tap range is split evenly over a fixed row of cells
  localparam int CELLS = 4;
  localparam int CELL_W = $clog2(CELLS);

  localparam int SAMPLE_W = 16;
  localparam int ACC_W = 48;
  localparam int CMD_W = 2;
  localparam int TAP_IDX_W = 10;
  localparam int COUNT_W = 11;
  localparam int Q_SHIFT = 15;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAP_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR_HIST = 2'd2;

  localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = 11'd1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [COUNT_W-1:0] tap_count_t;

  localparam acc_t ROUND_BIAS = 48'sd16384;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [TAP_IDX_W-1:0] tap_index;
    logic signed [SAMPLE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic clipped;
  } result_t;

  // strobes broadcast from the sequencer to every cell and the pre-delay
  typedef struct packed {
    logic hist_rd;
    logic hist_we;
    logic mac_rd;
    logic acc_clr;
    logic drain;
  } pcf_ctrl_t;

endpackage

@@ rtl/pcf_stream_if.sv @@
`timescale 1ns / 1ps
interface pcf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/partitioned_convolution_filter_unit.sv @@
`timescale 1ns / 1ps
// sample transfer to result: through the shift, tap loop, drain and finish states, SEG = taps per cell
// a new sample is taken only once the last one has reached the result register, held back by the per-cell tap loop
// tap writes and history clears are done in the idle state and give no result
// reset: synchronous, active high; then a clear pass zeroes the tap store, request blocked
module partitioned_convolution_filter_unit import pcf_pkg::*; #(
  parameter int PARTITION = 256,
  parameter int MAX_TAPS = 1024,
  parameter int HISTORY_DEPTH = 2048
) (
  input logic clk,
  input logic rst,
  pcf_stream_if.sink request,
  pcf_stream_if.source result,
  pcf_stream_if.sink cfg
);

  // taps per cell, rounded up to a power of two so cell addressing is a mask
  localparam int SEG_MIN = (MAX_TAPS + CELLS - 1) / CELLS;
  localparam int AW = (SEG_MIN <= 2) ? 1 : $clog2(SEG_MIN);
  localparam int SEG = 1 << AW;
  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int TW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = $clog2(PARTITION + CELLS * SEG + HISTORY_DEPTH + 2048 + 1);
  localparam int XW0 = (AW + CELL_W > TAP_IDX_W) ? AW + CELL_W : TAP_IDX_W;
  localparam int XW = (XW0 > NW) ? XW0 : NW;
  localparam int CNT_MAX = (SEG + 1 > CELLS - 1) ? SEG + 1 : CELLS - 1;
  localparam int CNT_W = $clog2(CNT_MAX + 1);
  localparam int RW = ACC_W - Q_SHIFT;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_SHIFT_RD = 7'b0000100,
    ST_SHIFT_WR = 7'b0001000,
    ST_MAC      = 7'b0010000,
    ST_DRAIN    = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0] ptr;
  logic [AW-1:0] wslot;
  logic [FW-1:0] fill;
  tap_count_t tap_count;
  logic [TW-1:0] ntaps;
  sample_t smp;
  logic res_valid;
  result_t res_data;
  logic res_load;

  item_t req;
  logic req_take;
  logic [XW-1:0] idx_x;
  logic idx_ok;

  pcf_ctrl_t ctrl;
  logic [CELLS-1:0] tap_we;
  logic [AW-1:0] tap_addr;
  logic [AW-1:0] hist_addr;
  sample_t tap_data;

  sample_t pre_out;
  sample_t line_in [CELLS];
  sample_t line_out [CELLS];
  acc_t psum_in [CELLS];
  acc_t psum_out [CELLS];

  acc_t total;
  acc_t biased;
  logic signed [RW-1:0] rnd;
  logic sat_hi;
  logic sat_lo;
  sample_t sat_val;

  // ---------------------------------------------------------------------------
  // handshakes: config always taken, requests only while the sequencer idles,
  // result held in its own register so the next request can land meanwhile
  // ---------------------------------------------------------------------------
  assign req = request.data;
  assign request.ready = (state == ST_IDLE);
  assign req_take = request.valid && request.ready;
  assign cfg.ready = 1'b1;
  assign result.valid = res_valid;
  assign result.data = res_data;

  // tap index split into cell select (upper bits) and slot within the cell
  assign idx_x = XW'(req.tap_index);
  assign idx_ok = idx_x < XW'(MAX_TAPS);

  assign ntaps = (TW'(tap_count) > TW'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(tap_count);

  // the slot after the newest one holds the oldest sample of each cell
  assign wslot = ptr + 1'b1;

  assign res_load = (state == ST_FINISH) && (!res_valid || result.ready);

  // ---------------------------------------------------------------------------
  // strobes and shared addresses for the cell row
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl = '0;
    tap_we = '0;
    tap_addr = idx_x[AW-1:0];
    tap_data = req.value;
    hist_addr = wslot;
    unique case (state)
      ST_CLEAR: begin
        // zero one row of taps across all cells each cycle
        tap_we = '1;
        tap_addr = cnt[AW-1:0];
        tap_data = '0;
      end
      ST_IDLE: begin
        if (req_take && req.command == CMD_TAP_WRITE && idx_ok) begin
          tap_we = {{(CELLS - 1){1'b0}}, 1'b1} << idx_x[AW +: CELL_W];
        end
      end
      ST_SHIFT_RD: begin
        // pull every cell's oldest sample before the line moves
        ctrl.hist_rd = 1'b1;
        ctrl.acc_clr = 1'b1;
      end
      ST_SHIFT_WR: begin
        // each cell stores what its left neighbor just dropped
        ctrl.hist_we = 1'b1;
      end
      ST_MAC: begin
        // slot j of every cell pairs tap j with the sample j places older
        ctrl.mac_rd = (cnt < CNT_W'(SEG));
        tap_addr = cnt[AW-1:0];
        hist_addr = ptr - cnt[AW-1:0];
      end
      ST_DRAIN: begin
        ctrl.drain = 1'b1;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      ptr <= '0;
      fill <= '0;
      tap_count <= TAP_COUNT_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        tap_count <= cfg.data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (cnt == CNT_W'(SEG - 1)) begin
            cnt <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_take) begin
            if (req.command == CMD_SAMPLE) begin
              state <= ST_SHIFT_RD;
            end else if (req.command == CMD_CLEAR_HIST) begin
              // stale line contents are masked by the fill count
              fill <= '0;
            end
          end
        end
        ST_SHIFT_RD: begin
          state <= ST_SHIFT_WR;
        end
        ST_SHIFT_WR: begin
          ptr <= wslot;
          fill <= (fill == FW'(HISTORY_DEPTH)) ? fill : fill + 1'b1;
          cnt <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          // the counts past the last tap flush the read and multiply registers
          if (cnt == CNT_W'(SEG + 1)) begin
            cnt <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          // partial sums ripple one cell per cycle to the end of the row
          if (cnt == CNT_W'(CELLS - 1)) begin
            cnt <= '0;
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_take && req.command == CMD_SAMPLE) begin
      smp <= req.value;
    end
    if (res_load) begin
      res_data.sample_out <= sat_val;
      res_data.clipped <= sat_hi || sat_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // pre-delay of PARTITION-1 samples ahead of the first tap cell
  // ---------------------------------------------------------------------------
  if (PARTITION > 1) begin : g_pre
    pcf_delay #(
      .DEPTH(PARTITION - 1)
    ) u_pre (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .din(smp),
      .dout(pre_out)
    );
  end else begin : g_no_pre
    assign pre_out = smp;
  end

  // ---------------------------------------------------------------------------
  // row of tap cells: samples move right on each shift, sums move right on drain
  // ---------------------------------------------------------------------------
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    if (c == 0) begin : g_head
      assign line_in[c] = pre_out;
      assign psum_in[c] = '0;
    end else begin : g_link
      assign line_in[c] = line_out[c-1];
      assign psum_in[c] = psum_out[c-1];
    end

    pcf_cell #(
      .CELL_IDX(c),
      .AW(AW),
      .PARTITION(PARTITION),
      .TW(TW),
      .FW(FW),
      .CW(CW)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .tap_we(tap_we[c]),
      .tap_addr(tap_addr),
      .tap_data(tap_data),
      .hist_addr(hist_addr),
      .sample_in(line_in[c]),
      .sample_out(line_out[c]),
      .ntaps(ntaps),
      .fill(fill),
      .psum_in(psum_in[c]),
      .psum_out(psum_out[c])
    );
  end

  // ---------------------------------------------------------------------------
  // round half up to Q1.15, then saturate
  // ---------------------------------------------------------------------------
  assign total = psum_out[CELLS-1];
  assign biased = total + ROUND_BIAS;
  assign rnd = biased[ACC_W-1:Q_SHIFT];
  assign sat_hi = rnd > RW'(SAMPLE_MAX);
  assign sat_lo = rnd < RW'(SAMPLE_MIN);
  assign sat_val = sat_hi ? SAMPLE_W'(SAMPLE_MAX)
                 : sat_lo ? SAMPLE_W'(SAMPLE_MIN)
                 : rnd[SAMPLE_W-1:0];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(HISTORY_DEPTH))
    else $error("history fill count ran past the history depth");

  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT_WR) |=> (ptr == AW'($past(ptr) + 1'b1)))
    else $error("line pointer did not advance by one on a shift");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.command == CMD_SAMPLE) |=> (state == ST_SHIFT_RD))
    else $error("sample transfer did not start a shift");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (res_valid && state == ST_IDLE))
    else $error("finished sum was not placed in the result register");

endmodule

@@ rtl/pcf_delay.sv @@
`timescale 1ns / 1ps
module pcf_delay import pcf_pkg::*; #(
  parameter int DEPTH = 255
) (
  input logic clk,
  input logic rst,
  input pcf_ctrl_t ctrl,
  input sample_t din,
  output sample_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sample_t mem [DEPTH];
  sample_t q;
  logic [PW-1:0] ptr;

  // circular line: the slot about to be overwritten holds the oldest sample
  always_ff @(posedge clk) begin
    if (ctrl.hist_we) begin
      mem[ptr] <= din;
    end
    if (ctrl.hist_rd) begin
      q <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.hist_we) begin
      ptr <= (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    end
  end

  assign dout = q;

endmodule

@@ rtl/pcf_cell.sv @@
`timescale 1ns / 1ps
module pcf_cell import pcf_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int AW = 8,
  parameter int PARTITION = 256,
  parameter int TW = 11,
  parameter int FW = 12,
  parameter int CW = 13
) (
  input logic clk,
  input logic rst,
  input pcf_ctrl_t ctrl,
  input logic tap_we,
  input logic [AW-1:0] tap_addr,
  input sample_t tap_data,
  input logic [AW-1:0] hist_addr,
  input sample_t sample_in,
  output sample_t sample_out,
  input logic [TW-1:0] ntaps,
  input logic [FW-1:0] fill,
  input acc_t psum_in,
  output acc_t psum_out
);

  localparam int SEG = 1 << AW;
  localparam int TAP_BASE = CELL_IDX * SEG;
  localparam int DEL_BASE = PARTITION - 1 + TAP_BASE;

  sample_t tap_mem [SEG];
  sample_t hist_mem [SEG];
  sample_t tap_q;
  sample_t hist_q;
  logic in_use;
  logic in_use_q;
  logic signed [2*SAMPLE_W-1:0] prod;
  acc_t acc;
  acc_t psum;

  // tap counts only below tap_count and while its sample is younger than the fill
  assign in_use = ctrl.mac_rd
      && ((CW'(TAP_BASE) + CW'(tap_addr)) < CW'(ntaps))
      && ((CW'(DEL_BASE) + CW'(tap_addr)) < CW'(fill));

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_addr] <= tap_data;
    end
    if (ctrl.mac_rd) begin
      tap_q <= tap_mem[tap_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.hist_we) begin
      hist_mem[hist_addr] <= sample_in;
    end
    if (ctrl.hist_rd || ctrl.mac_rd) begin
      hist_q <= hist_mem[hist_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use_q <= 1'b0;
    end else begin
      in_use_q <= in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (in_use_q) begin
      prod <= tap_q * hist_q;
    end else begin
      prod <= '0;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.drain) begin
      psum <= acc + psum_in;
    end
  end

  assign sample_out = hist_q;
  assign psum_out = psum;

endmodule
